// File: src/bufuart_pkg.sv
// Package for the buffered UART front end: types, codes and constants
// shared by the controller, the datapath and the top level. No dependencies.
package bufuart_pkg;

  localparam int DATA_W = 8;
  localparam int FUNC_W = 2;

  // Item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE    = 2'd0,
    FUNC_READ     = 2'd1,
    FUNC_RX_EVENT = 2'd2,
    FUNC_TX_READY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TX_FETCH,
    ST_RX_FETCH
  } ctrl_state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic tx_push;
    logic rx_push;
    logic tx_pop;
    logic rx_pop;
    logic irq_set;
    logic irq_clr;
    logic res_load;
    logic res_ok;
    logic res_tx;
    logic res_rx;
    logic res_drop;
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic tx_empty;
    logic tx_full;
    logic rx_empty;
    logic rx_full;
  } dp_stat_t;

  // Result transaction payload
  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_data;
    logic              line_send;
    logic [DATA_W-1:0] line_byte;
    logic              tx_irq_enable;
    logic              rx_dropped;
  } res_t;

endpackage

// File: src/bufuart_if.sv
// Channel interfaces for the buffered UART front end (valid/ready).
// Depends on bufuart_pkg for field widths.
interface bufuart_in_if;
  logic                           valid;
  logic                           ready;
  logic [bufuart_pkg::FUNC_W-1:0] func;
  logic [bufuart_pkg::DATA_W-1:0] data;

  modport source (output valid, output func, output data, input ready);
  modport sink (input valid, input func, input data, output ready);
endinterface

interface bufuart_out_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [bufuart_pkg::DATA_W-1:0] read_data;
  logic                           line_send;
  logic [bufuart_pkg::DATA_W-1:0] line_byte;
  logic                           tx_irq_enable;
  logic                           rx_dropped;

  modport source (output valid, output ok, output read_data, output line_send,
                  output line_byte, output tx_irq_enable, output rx_dropped,
                  input ready);
  modport sink (input valid, input ok, input read_data, input line_send,
                input line_byte, input tx_irq_enable, input rx_dropped,
                output ready);
endinterface

// File: src/bufuart_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bufuart_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/bufuart_dp.sv
// Datapath: transmit and receive queues (RAM, head/tail/count), transmit
// interrupt flag and result register. Depends on bufuart_pkg, bufuart_ram.
module bufuart_dp #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bufuart_pkg::dp_cmd_t           cmd,
  input  logic [bufuart_pkg::DATA_W-1:0] in_data,
  output bufuart_pkg::dp_stat_t          stat,
  output bufuart_pkg::res_t              res
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [AW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [AW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [CW-1:0] tx_count_r, tx_count_nxt, rx_count_r, rx_count_nxt;
  logic          irq_r, irq_nxt;
  logic [bufuart_pkg::DATA_W-1:0] tx_rdata, rx_rdata;
  bufuart_pkg::res_t res_r;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  bufuart_ram #(.WIDTH(bufuart_pkg::DATA_W), .DEPTH(QUEUE_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (cmd.tx_push),
    .waddr (tx_tail_r),
    .wdata (in_data),
    .re    (cmd.tx_pop),
    .raddr (tx_head_r),
    .rdata (tx_rdata)
  );

  bufuart_ram #(.WIDTH(bufuart_pkg::DATA_W), .DEPTH(QUEUE_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (cmd.rx_push),
    .waddr (rx_tail_r),
    .wdata (in_data),
    .re    (cmd.rx_pop),
    .raddr (rx_head_r),
    .rdata (rx_rdata)
  );

  always_comb begin
    tx_tail_nxt  = cmd.tx_push ? wrap_inc(tx_tail_r) : tx_tail_r;
    tx_head_nxt  = cmd.tx_pop ? wrap_inc(tx_head_r) : tx_head_r;
    rx_tail_nxt  = cmd.rx_push ? wrap_inc(rx_tail_r) : rx_tail_r;
    rx_head_nxt  = cmd.rx_pop ? wrap_inc(rx_head_r) : rx_head_r;
    // push and pop of one queue never coincide (one transaction at a time)
    tx_count_nxt = tx_count_r;
    if (cmd.tx_push) begin
      tx_count_nxt = tx_count_r + CW'(1);
    end else if (cmd.tx_pop) begin
      tx_count_nxt = tx_count_r - CW'(1);
    end
    rx_count_nxt = rx_count_r;
    if (cmd.rx_push) begin
      rx_count_nxt = rx_count_r + CW'(1);
    end else if (cmd.rx_pop) begin
      rx_count_nxt = rx_count_r - CW'(1);
    end
    irq_nxt = cmd.irq_set ? 1'b1 : (cmd.irq_clr ? 1'b0 : irq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r  <= '0;
      tx_tail_r  <= '0;
      tx_count_r <= '0;
      rx_head_r  <= '0;
      rx_tail_r  <= '0;
      rx_count_r <= '0;
      irq_r      <= 1'b0;
    end else begin
      tx_head_r  <= tx_head_nxt;
      tx_tail_r  <= tx_tail_nxt;
      tx_count_r <= tx_count_nxt;
      rx_head_r  <= rx_head_nxt;
      rx_tail_r  <= rx_tail_nxt;
      rx_count_r <= rx_count_nxt;
      irq_r      <= irq_nxt;
    end
  end

  // Result register; RAM read data is valid in the fetch cycle
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r.ok            <= cmd.res_ok;
      res_r.read_data     <= cmd.res_rx ? rx_rdata : '0;
      res_r.line_send     <= cmd.res_tx;
      res_r.line_byte     <= cmd.res_tx ? tx_rdata : '0;
      res_r.tx_irq_enable <= irq_nxt;
      res_r.rx_dropped    <= cmd.res_drop;
    end
  end

  assign stat.tx_empty = (tx_count_r == '0);
  assign stat.tx_full  = (tx_count_r == CW'(QUEUE_DEPTH));
  assign stat.rx_empty = (rx_count_r == '0);
  assign stat.rx_full  = (rx_count_r == CW'(QUEUE_DEPTH));
  assign res = res_r;

endmodule

// File: src/bufuart_ctrl.sv
// Controller: decodes each transaction, sequences queue pushes and pops and
// owns the result valid flag. Depends on bufuart_pkg.
module bufuart_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [bufuart_pkg::FUNC_W-1:0] in_func,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  bufuart_pkg::dp_stat_t          stat,
  output bufuart_pkg::dp_cmd_t           cmd
);

  bufuart_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_ready = (state_r == bufuart_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bufuart_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      bufuart_pkg::ST_IDLE: begin
        if (accept) begin
          case (bufuart_pkg::func_t'(in_func))
            bufuart_pkg::FUNC_WRITE: begin
              cmd.res_load = 1'b1;
              if (!stat.tx_full) begin
                cmd.tx_push = 1'b1;
                cmd.irq_set = 1'b1;
                cmd.res_ok  = 1'b1;
              end
            end
            bufuart_pkg::FUNC_READ: begin
              if (!stat.rx_empty) begin
                cmd.rx_pop = 1'b1;
                state_nxt  = bufuart_pkg::ST_RX_FETCH;
              end else begin
                cmd.res_load = 1'b1;
              end
            end
            bufuart_pkg::FUNC_RX_EVENT: begin
              cmd.res_load = 1'b1;
              if (!stat.rx_full) begin
                cmd.rx_push = 1'b1;
              end else begin
                cmd.res_drop = 1'b1;
              end
            end
            bufuart_pkg::FUNC_TX_READY: begin
              if (!stat.tx_empty) begin
                cmd.tx_pop = 1'b1;
                state_nxt  = bufuart_pkg::ST_TX_FETCH;
              end else begin
                cmd.irq_clr  = 1'b1;
                cmd.res_load = 1'b1;
              end
            end
            default: begin
              cmd.res_load = 1'b1;
            end
          endcase
        end
      end
      bufuart_pkg::ST_RX_FETCH: begin
        cmd.res_load = 1'b1;
        cmd.res_ok   = 1'b1;
        cmd.res_rx   = 1'b1;
        state_nxt    = bufuart_pkg::ST_IDLE;
      end
      bufuart_pkg::ST_TX_FETCH: begin
        cmd.res_load = 1'b1;
        cmd.res_tx   = 1'b1;
        state_nxt    = bufuart_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bufuart_pkg::ST_IDLE;
      end
    endcase

    // result register is always free when a load is issued
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: src/buffered_uart_fifo_interface.sv
// Buffered UART data front end: a transmit queue and a receive queue of
// QUEUE_DEPTH bytes each, driven by one transaction per item on in_ch
// (software write, software read, received-byte event, transmitter-ready
// event) and answering with exactly one result transaction on out_ch.
// A software write, a received byte, a read of an empty receive queue and a
// transmitter-ready event on an empty transmit queue load the result register
// when accepted; a read or transmitter-ready that pops a byte passes through a
// fetch state, because the byte comes from the queue RAM's registered read
// port. The result sits in an output register, so the next transaction is
// taken in the same cycle the previous result is taken. Queue RAMs are not
// cleared after reset; only entries written earlier are ever read. Depends on
// bufuart_pkg, bufuart_if, bufuart_ram, bufuart_ctrl and bufuart_dp.
module buffered_uart_fifo_interface #(
  parameter int QUEUE_DEPTH = 256
) (
  input logic          clk,
  input logic          rst_n,
  bufuart_in_if.sink   in_ch,
  bufuart_out_if.source out_ch
);

  bufuart_pkg::dp_cmd_t  cmd;
  bufuart_pkg::dp_stat_t stat;
  bufuart_pkg::res_t     res;
  logic                  in_accept;

  // Controller: decode and sequencing
  bufuart_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: queues, interrupt enable, result register
  bufuart_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_ch.data),
    .stat    (stat),
    .res     (res)
  );

  assign out_ch.ok            = res.ok;
  assign out_ch.read_data     = res.read_data;
  assign out_ch.line_send     = res.line_send;
  assign out_ch.line_byte     = res.line_byte;
  assign out_ch.tx_irq_enable = res.tx_irq_enable;
  assign out_ch.rx_dropped    = res.rx_dropped;

  assign in_accept = in_ch.valid && in_ch.ready;

  // Never take new work while a pending result is stuck
  a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!out_ch.valid || out_ch.ready))
    else $error("input ready while result register blocked");

  // An accepted transaction with no result yet means a RAM fetch is in flight
  a_fetch_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(in_accept) && !out_ch.valid) |-> !in_ch.ready)
    else $error("input ready during queue fetch");

  // A byte can only go out while the transmit interrupt is enabled
  a_send_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.line_send) |-> out_ch.tx_irq_enable)
    else $error("byte sent with transmit interrupt disabled");

  // Result flags are mutually exclusive
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ok) |-> (!out_ch.line_send && !out_ch.rx_dropped))
    else $error("ok set together with a line event flag");

  // A queue is never both empty and full
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.tx_empty && stat.tx_full) && !(stat.rx_empty && stat.rx_full))
    else $error("queue reports empty and full at once");

endmodule
